@@ sv/keq_pkg.sv @@
// Shared types and constants for the key event queue.
`default_nettype none
package keq_pkg;
   localparam int NUM_KEYS = 127;
   localparam int FIFO_DEPTH_DEF = 16;
   localparam logic [15:0] SAFETY_RST = 16'd500;
   localparam logic [15:0] DELAY_RST = 16'd500;
   localparam logic [15:0] RATE_RST = 16'd100;
   localparam logic [7:0] REL_FLAG = 8'h80;
   localparam logic [7:0] ST_PRESS = 8'h01;
   localparam logic [7:0] ST_RELEASE = 8'h03;
   localparam logic [7:0] BACKSPACE = 8'h08;
   localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

   typedef enum logic [2:0] {
      KIND_REPORT = 3'd0, KIND_TICK = 3'd1, KIND_GET = 3'd2,
      KIND_FLUSH = 3'd3, KIND_PUSH = 3'd4, KIND_QUERY = 3'd5,
      KIND_RSV6 = 3'd6, KIND_RSV7 = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SAFETY = 2'd0, CSR_DELAY = 2'd1, CSR_RATE = 2'd2, CSR_NONE = 2'd3
   } csr_type;

   // classified command passed from front to back
   typedef struct packed {
      kind_type   kind;
      logic       press;
      logic       release_edge;
      logic [6:0] key;
      logic [7:0] code;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD, ST_EXEC, ST_TICK, ST_GETWAIT, ST_GETEVAL, ST_REPEAT
   } state_type;

   function automatic logic [7:0] map_code(input logic [7:0] c);
      logic [7:0] r;
      begin
         case (c)
            8'hB5: r = 8'd1;
            8'hB4: r = 8'd2;
            8'hB7: r = 8'd3;
            8'hB6: r = 8'd4;
            8'h83: r = 8'd5;
            8'h84: r = 8'd6;
            8'h81: r = 8'd7;
            8'h82: r = 8'd8;
            default: begin
               if (c[7]) r = 8'd0;
               else if (c == BACKSPACE) r = 8'h7F;
               else r = c;
            end
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

@@ sv/key_event_queue_with_repeat_top.sv @@
// Top level: configuration registers, command front end and execution back end.
// A get skips queued release events before it answers.
// A tick walks the key timer RAM one entry at a time.
// Results come as a one-cycle rsp_valid strobe; the receiver cannot stall.
// Synchronous reset clears key state, queue pointers and loads default registers.
`default_nettype none
module key_event_queue_with_repeat_top #(
   parameter int FIFO_DEPTH = keq_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_status,
   input  wire logic [7:0]  req_code,
   output      logic        rsp_valid,
   output      logic [7:0]  rsp_key,
   output      logic        rsp_pressed,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import keq_pkg::*;
   logic [15:0] safety_ff, delay_ff, rate_ff;
   logic cmd_valid, pop;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         safety_ff <= SAFETY_RST; delay_ff <= DELAY_RST; rate_ff <= RATE_RST;
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_SAFETY: safety_ff <= csr_data;
            CSR_DELAY:  delay_ff <= csr_data;
            CSR_RATE:   rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   keq_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_kind(req_kind),
      .req_status(req_status), .req_code(req_code), .pop(pop), .busy(busy),
      .cmd_valid(cmd_valid), .cmd(cmd));

   keq_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd), .pop(pop),
      .auto_release_ticks(safety_ff), .repeat_delay(delay_ff),
      .repeat_rate(rate_ff),
      .rsp_valid(rsp_valid), .rsp_key(rsp_key), .rsp_pressed(rsp_pressed));
endmodule
`default_nettype wire

@@ sv/keq_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module keq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ sv/keq_front.sv @@
// Front end: accepts and classifies commands into a short queue.
`default_nettype none
module keq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [2:0]        req_kind,
   input  wire logic [7:0]        req_status,
   input  wire logic [7:0]        req_code,
   input  wire logic              pop,
   output      logic              busy,
   output      logic              cmd_valid,
   output      keq_pkg::cmd_type  cmd
);
   import keq_pkg::*;
   cmd_type q_ff [2];
   cmd_type cls;
   logic [1:0] cnt_ff, cnt_in;
   logic rp_ff, rp_in, wp_ff, wp_in, push;
   logic [7:0] k;

   // classify the incoming item
   always_comb begin
      k = map_code(req_code);
      cls.kind = kind_type'(req_kind);
      cls.code = req_code;
      cls.key = k[6:0];
      cls.press = (req_code != 8'd0) && (k != 8'd0) && (req_status == ST_PRESS);
      cls.release_edge = (req_code != 8'd0) && (k != 8'd0) && (req_status == ST_RELEASE);
   end

   assign busy = (cnt_ff != 2'd0);
   assign push = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rp_ff];

   // advance queue pointers
   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) q_ff[wp_ff] <= cls;
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !(cnt_ff == 2'd2)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cmd_valid) else $error("pop of empty queue");
   a_busy_after_push: assert property (@(posedge clock) disable iff (reset)
      push |=> busy) else $error("busy not raised");
`endif
endmodule
`default_nettype wire

@@ sv/keq_back.sv @@
// Back end: key state, timers, event FIFO and get/repeat sequencing.
`default_nettype none
module keq_back #(
   parameter int FIFO_DEPTH = keq_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire keq_pkg::cmd_type cmd,
   output      logic             pop,
   input  wire logic [15:0]      auto_release_ticks,
   input  wire logic [15:0]      repeat_delay,
   input  wire logic [15:0]      repeat_rate,
   output      logic             rsp_valid,
   output      logic [7:0]       rsp_key,
   output      logic             rsp_pressed
);
   import keq_pkg::*;
   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int KW = 7;

   state_type st_ff, st_in;
   logic [NUM_KEYS-1:0] held_ff, held_in;
   logic [NUM_KEYS-1:0] tvalid_ff, tvalid_in;
   logic [AW-1:0] wpos_ff, wpos_in, rpos_ff, rpos_in;
   logic [7:0] pb_ff, pb_in;
   logic [6:0] rk_ff, rk_in;
   logic [31:0] due_ff, due_in, now_ff, now_in;
   logic [KW-1:0] idx_ff, idx_in;
   logic [4:0] guard_ff, guard_in;
   logic [7:0] ev_ff, ev_in;
   logic rv_ff, rv_in, rp_ff, rp_in;
   logic [7:0] rkey_ff, rkey_in;

   logic t_we;
   logic [KW-1:0] t_wa, t_ra;
   logic [15:0] t_wd, t_rd;
   logic f_we;
   logic [7:0] f_rd;
   logic [AW-1:0] wnext, rnext;
   logic [15:0] tcur, tdec;
   logic [6:0] ki;

   // timers live in RAM; tvalid marks entries written since reset
   keq_ram #(.WIDTH(16), .DEPTH(NUM_KEYS)) u_timer (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd));

   keq_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .wr_en(f_we), .wr_addr(wpos_ff), .wr_data(ev_ff),
      .rd_addr(rpos_ff), .rd_data(f_rd));

   assign wnext = (wpos_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
   assign rnext = (rpos_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rpos_ff + 1'b1;
   assign ki = cmd.key - 7'd1;
   assign tcur = tvalid_ff[idx_ff] ? t_rd : 16'd0;
   assign tdec = tcur - 16'd1;

   // sequencer
   always_comb begin
      st_in = st_ff; held_in = held_ff; tvalid_in = tvalid_ff;
      wpos_in = wpos_ff; rpos_in = rpos_ff; pb_in = pb_ff; rk_in = rk_ff;
      due_in = due_ff; now_in = now_ff; idx_in = idx_ff; guard_in = guard_ff;
      ev_in = ev_ff; rv_in = 1'b0; rp_in = 1'b0; rkey_in = 8'd0;
      pop = 1'b0; t_we = 1'b0; t_wa = idx_ff; t_wd = 16'd0; t_ra = idx_ff;
      f_we = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  KIND_REPORT: begin
                     pop = 1'b1;
                     if (cmd.press) begin
                        t_we = 1'b1; t_wa = ki; t_wd = auto_release_ticks;
                        tvalid_in[ki] = 1'b1;
                        if (!held_ff[ki]) begin
                           held_in[ki] = 1'b1;
                           ev_in = {1'b0, cmd.key};
                           st_in = ST_EXEC;
                        end
                     end else if (cmd.release_edge) begin
                        t_we = 1'b1; t_wa = ki; t_wd = 16'd0;
                        tvalid_in[ki] = 1'b1;
                        if (held_ff[ki]) begin
                           held_in[ki] = 1'b0;
                           ev_in = {1'b1, cmd.key};
                           st_in = ST_EXEC;
                        end
                     end
                  end
                  KIND_TICK: begin
                     pop = 1'b1;
                     now_in = now_ff + 32'd1;
                     idx_in = '0; t_ra = '0;
                     st_in = ST_TICK;
                  end
                  KIND_GET: begin
                     pop = 1'b1;
                     guard_in = '0;
                     st_in = ST_RD;
                  end
                  KIND_FLUSH: begin
                     pop = 1'b1; wpos_in = rpos_ff; pb_in = 8'd0;
                  end
                  KIND_PUSH: begin
                     pop = 1'b1; pb_in = cmd.code;
                  end
                  KIND_QUERY: begin
                     pop = 1'b1; rv_in = 1'b1;
                     rp_in = (cmd.code != 8'd0) && !cmd.code[7] &&
                        held_ff[cmd.code[6:0] - 7'd1];
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_EXEC: begin
            // push event unless full
            if (wnext != rpos_ff) begin
               f_we = 1'b1; wpos_in = wnext;
            end
            st_in = ST_IDLE;
         end
         ST_TICK: begin
            // timer read data for idx_ff is present now
            if (tcur != 16'd0) begin
               t_we = 1'b1; t_wd = tdec; tvalid_in[idx_ff] = 1'b1;
               if (tdec == 16'd0) held_in[idx_ff] = 1'b0;
            end
            if (idx_ff == KW'(NUM_KEYS - 1)) st_in = ST_IDLE;
            else begin
               idx_in = idx_ff + 1'b1; t_ra = idx_ff + 1'b1;
               st_in = ST_GETWAIT;
            end
         end
         ST_GETWAIT: begin
            // wait for the next timer read
            st_in = ST_TICK;
         end
         ST_RD: begin
            // fetch next event
            guard_in = guard_ff + 5'd1;
            if (pb_ff != 8'd0) begin
               ev_in = pb_ff; pb_in = 8'd0; guard_in = 5'h1E;
               st_in = ST_GETEVAL;
            end else if (rpos_ff == wpos_ff) begin
               st_in = ST_REPEAT;
            end else begin
               rpos_in = rnext; guard_in = 5'h1D;
               st_in = ST_GETEVAL;
            end
         end
         ST_GETEVAL: begin
            if (guard_ff == 5'h1D) ev_in = f_rd;
            if ((guard_ff == 5'h1D ? f_rd[7] : ev_ff[7]) == 1'b0) begin
               rk_in = (guard_ff == 5'h1D) ? f_rd[6:0] : ev_ff[6:0];
               due_in = now_ff + {16'd0, repeat_delay};
               rv_in = 1'b1;
               rkey_in = (guard_ff == 5'h1D) ? f_rd : ev_ff;
               st_in = ST_IDLE;
            end else begin
               if (((guard_ff == 5'h1D) ? f_rd[6:0] : ev_ff[6:0]) == rk_ff)
                  rk_in = 7'd0;
               st_in = ST_RD;
            end
         end
         ST_REPEAT: begin
            rv_in = 1'b1;
            if (rk_ff != 7'd0) begin
               if (held_ff[rk_ff - 7'd1]) begin
                  if ((now_ff - due_ff) < HALF_RANGE) begin
                     due_in = now_ff + {16'd0, repeat_rate};
                     rkey_in = {1'b0, rk_ff};
                  end
               end else rk_in = 7'd0;
            end
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; held_ff <= '0; tvalid_ff <= '0;
         wpos_ff <= '0; rpos_ff <= '0; pb_ff <= '0; rk_ff <= '0;
         due_ff <= '0; now_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; held_ff <= held_in; tvalid_ff <= tvalid_in;
         wpos_ff <= wpos_in; rpos_ff <= rpos_in; pb_ff <= pb_in; rk_ff <= rk_in;
         due_ff <= due_in; now_ff <= now_in; rv_ff <= rv_in;
      end
      idx_ff <= idx_in; guard_ff <= guard_in; ev_ff <= ev_in;
      rp_ff <= rp_in; rkey_ff <= rkey_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_key = rkey_ff;
   assign rsp_pressed = rp_ff;

`ifndef SYNTH
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pressed && rsp_key != 8'd0)) else $error("mixed result");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> st_ff == ST_IDLE) else $error("pop outside idle");
   a_fifo_nofill: assert property (@(posedge clock) disable iff (reset)
      f_we |-> wnext != rpos_ff) else $error("fifo overrun");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the key event queue with auto-repeat.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import keq_pkg::*;

   localparam int DEPTH = 16;
   localparam int WATCH_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_status = '0;
   logic [7:0]  req_code = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_key;
   logic        rsp_pressed;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   key_event_queue_with_repeat_top #(.FIFO_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_status(req_status), .req_code(req_code),
      .rsp_valid(rsp_valid), .rsp_key(rsp_key), .rsp_pressed(rsp_pressed),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // predicted keyboard state
   logic [15:0] p_safety, p_delay, p_rate;
   logic        p_held [NUM_KEYS];
   logic [15:0] p_timer [NUM_KEYS];
   logic [7:0]  p_store [DEPTH];
   int unsigned p_wr, p_rd;
   logic [7:0]  p_back;
   logic [7:0]  p_rep_key;
   logic [31:0] p_rep_due, p_now;

   typedef struct packed {
      logic [7:0] key;
      logic       pressed;
   } answer_type;
   answer_type answers_due [$];

   int errors = 0;
   int items_sent = 0;
   int answers_seen = 0;
   int idle_cycles = 0;
   int gets_nonzero = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic [7:0] key_of(input logic [7:0] c);
      case (c)
         8'hB5: return 8'd1;
         8'hB4: return 8'd2;
         8'hB7: return 8'd3;
         8'hB6: return 8'd4;
         8'h83: return 8'd5;
         8'h84: return 8'd6;
         8'h81: return 8'd7;
         8'h82: return 8'd8;
         default: ;
      endcase
      if (c[7]) return 8'd0;
      return (c == BACKSPACE) ? 8'h7F : c;
   endfunction

   function automatic void queue_event(input logic [7:0] v);
      int unsigned n;
      n = (p_wr + 1 >= DEPTH) ? 0 : p_wr + 1;
      if (n != p_rd) begin
         p_store[p_wr] = v;
         p_wr = n;
      end
   endfunction

   function automatic logic held_key(input logic [7:0] k);
      if (k < 1 || k > NUM_KEYS) return 1'b0;
      return p_held[k - 1];
   endfunction

   function automatic logic [7:0] pop_event();
      logic [7:0] v;
      v = p_back;
      if (v != 0) begin
         p_back = 0;
         return v;
      end
      if (p_rd == p_wr) return 8'd0;
      v = p_store[p_rd];
      p_rd = (p_rd + 1 >= DEPTH) ? 0 : p_rd + 1;
      return v;
   endfunction

   function automatic logic [7:0] next_key();
      logic [7:0] ev;
      logic [31:0] diff;
      for (int g = 0; g <= DEPTH + 1; g++) begin
         ev = pop_event();
         if (ev == 0) break;
         if ((ev & REL_FLAG) == 0) begin
            p_rep_key = ev;
            p_rep_due = p_now + {16'd0, p_delay};
            return ev;
         end
         if ((ev & 8'h7F) == p_rep_key) p_rep_key = 0;
      end
      if (p_rep_key != 0) begin
         if (held_key(p_rep_key)) begin
            diff = p_now - p_rep_due;
            if (diff < HALF_RANGE) begin
               p_rep_due = p_now + {16'd0, p_rate};
               return p_rep_key;
            end
         end else begin
            p_rep_key = 0;
         end
      end
      return 8'd0;
   endfunction

   // advance the predicted state by one transaction
   function automatic void predict(input logic [2:0] kind, input logic [7:0] st,
                                   input logic [7:0] code);
      logic [7:0] k;
      answer_type a;
      case (kind_type'(kind))
         KIND_REPORT: begin
            k = key_of(code);
            if (code != 0 && k != 0) begin
               if (st == ST_PRESS) begin
                  if (!p_held[k - 1]) begin
                     p_held[k - 1] = 1'b1;
                     queue_event(k & 8'h7F);
                  end
                  p_timer[k - 1] = p_safety;
               end else if (st == ST_RELEASE) begin
                  if (p_held[k - 1]) begin
                     p_held[k - 1] = 1'b0;
                     queue_event(k | REL_FLAG);
                  end
                  p_timer[k - 1] = 16'd0;
               end
            end
         end
         KIND_TICK: begin
            p_now = p_now + 32'd1;
            for (int i = 0; i < NUM_KEYS; i++)
               if (p_timer[i] > 0) begin
                  p_timer[i] = p_timer[i] - 16'd1;
                  if (p_timer[i] == 0) p_held[i] = 1'b0;
               end
         end
         KIND_GET: begin
            a.key = next_key();
            a.pressed = 1'b0;
            if (a.key != 0) gets_nonzero++;
            answers_due.push_back(a);
         end
         KIND_FLUSH: begin
            p_wr = p_rd;
            p_back = 0;
         end
         KIND_PUSH: p_back = code;
         KIND_QUERY: begin
            a.key = 8'd0;
            a.pressed = held_key(code);
            answers_due.push_back(a);
         end
         default: ;
      endcase
   endfunction

   function automatic void model_reset();
      p_safety = SAFETY_RST;
      p_delay = DELAY_RST;
      p_rate = RATE_RST;
      for (int i = 0; i < NUM_KEYS; i++) begin
         p_held[i] = 1'b0;
         p_timer[i] = 16'd0;
      end
      p_wr = 0;
      p_rd = 0;
      p_back = 0;
      p_rep_key = 0;
      p_rep_due = 0;
      p_now = 0;
   endfunction

   // check each answer against the oldest prediction
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid) begin
         answers_seen++;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("unexpected answer key=%0h", rsp_key));
         end else begin
            a = answers_due.pop_front();
            if (rsp_key !== a.key)
               report_mismatch($sformatf("key got %0h want %0h", rsp_key, a.key));
            if (rsp_pressed !== a.pressed)
               report_mismatch($sformatf("pressed got %b want %b",
                                         rsp_pressed, a.pressed));
         end
      end
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("watchdog expired");
         $display("Regression FAIL");
         $finish;
      end
   end

   // hold start high across back-to-back transactions; drop it only for a gap
   task automatic send_item(input logic [2:0] kind, input logic [7:0] st,
                            input logic [7:0] code);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_status <= st;
      req_code <= code;
      do @(posedge clock); while (busy);
      predict(kind, st, code);
      items_sent++;
   endtask

   task automatic write_reg(input csr_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SAFETY: p_safety = val;
         CSR_DELAY: p_delay = val;
         CSR_RATE: p_rate = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain all answers and let a queued item behind a tick finish
   task automatic settle();
      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic press(input logic [7:0] c);
      send_item(KIND_REPORT, ST_PRESS, c);
   endtask

   task automatic test_directed();
      press(8'hB5); press(8'hB4); press(8'hB7); press(8'hB6);
      press(8'h83); press(8'h84); press(8'h81); press(8'h82);
      press(BACKSPACE); press(8'h7F); press(8'h00); press(8'hFF);
      press(8'hB5);
      send_item(KIND_REPORT, 8'h02, 8'h41);
      send_item(KIND_REPORT, ST_RELEASE, 8'hB5);
      send_item(KIND_REPORT, ST_RELEASE, 8'h55);
      send_item(KIND_QUERY, 8'h00, 8'h7F);
      send_item(KIND_QUERY, 8'h00, 8'h00);
      send_item(KIND_QUERY, 8'hFF, 8'hFF);
      send_item(KIND_PUSH, 8'h00, 8'h85);
      send_item(KIND_GET, 8'h00, 8'h00);
      send_item(KIND_PUSH, 8'h00, 8'h00);
      send_item(KIND_FLUSH, 8'h00, 8'h00);
      send_item(KIND_RSV6, 8'h00, 8'h00);
      send_item(KIND_RSV7, 8'hFF, 8'hFF);
      settle();
   endtask

   // fill past capacity, then read everything back
   task automatic test_overflow();
      for (int i = 1; i <= 20; i++) press(i[7:0]);
      repeat (24) send_item(KIND_GET, 8'h00, 8'h00);
      settle();
   endtask

   // random sessions of reports, ticks, gets, queries, flushes, pushes and malformed items
   task automatic test_random(input int n);
      logic [2:0] kind;
      logic [7:0] st, code;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         st = ($urandom_range(0, 1) != 0) ? ST_PRESS : ST_RELEASE;
         code = ($urandom_range(0, 2) == 0) ? 8'(8'hB4 + $urandom_range(0, 3))
                                             : 8'($urandom_range(1, 12));
         if (r < 30) kind = KIND_REPORT;
         else if (r < 55) kind = KIND_TICK;
         else if (r < 78) kind = KIND_GET;
         else if (r < 88) begin
            kind = KIND_QUERY;
            if ($urandom_range(0, 3) == 0) code = 8'($urandom);
         end else if (r < 91) kind = KIND_FLUSH;
         else if (r < 94) begin
            kind = KIND_PUSH;
            code = 8'($urandom);
         end else begin
            kind = 3'($urandom);
            st = 8'($urandom);
            code = 8'($urandom);
         end
         send_item(kind, st, code);
      end
      settle();
   endtask

   task automatic test_settings();
      write_reg(CSR_SAFETY, 16'd5);
      write_reg(CSR_DELAY, 16'd3);
      write_reg(CSR_RATE, 16'd1);
      test_random(500);
      write_reg(CSR_SAFETY, 16'd1);
      write_reg(CSR_DELAY, 16'd1);
      write_reg(CSR_RATE, 16'd2);
      test_random(300);
      write_reg(CSR_SAFETY, 16'hFFFF);
      write_reg(CSR_DELAY, 16'hFFFF);
      write_reg(CSR_RATE, 16'hFFFF);
      test_random(300);
      write_reg(CSR_SAFETY, 16'd40);
      write_reg(CSR_DELAY, 16'd8);
      write_reg(CSR_RATE, 16'd4);
      test_random(400);
   endtask

   initial begin
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_random(100);
      test_settings();
      settle();
      $display("Sent %0d commands, checked %0d answers (%0d gets returned a key).",
               items_sent, answers_seen, gets_nonzero);
      if (errors == 0 && answers_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d answers missing", errors, answers_due.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ key_event_queue_with_repeat_top.f @@
sv/keq_pkg.sv
sv/keq_ram.sv
sv/keq_front.sv
sv/keq_back.sv
sv/key_event_queue_with_repeat_top.sv
tb/sv/tb_top.sv
